// ===== design/sha256_pkg.sv =====
// Package: SHA-256 constants, round table and controller command/status types.
`default_nettype none
package sha256_pkg;
   localparam int WordWidth  = 32;
   localparam int BlockBytes = 64;
   localparam int PadStart   = 56;

   localparam logic [255:0] InitHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   typedef struct packed {
      logic       wr_byte;     // write wr_data at fill position, advance fill
      logic [7:0] wr_data;
      logic       count_byte;  // bump message length
      logic       start_blk;   // load round vars from chain, clear round count
      logic       round_en;    // run one round
      logic       finish_blk;  // add round vars into chain
      logic       init_hash;   // restore initial hash, clear counts
      logic       len_sel;     // choose length byte as write data
      logic [2:0] len_idx;
      logic [2:0] out_idx;
   } ctrl_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       block_full;
      logic       last_round;
   } stat_type;

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction
endpackage
`default_nettype wire

// ===== design/sha256_if.sv =====
// Interfaces: request and response channels.
`default_nettype none
interface sha256_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;
   modport source (output valid, msg_byte, byte_present, end_of_message, input ready);
   modport sink (input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== design/sha256_datapath.sv =====
// Datapath: block buffer, message schedule, round logic, chaining words, length counter.
`default_nettype none
module sha256_datapath import sha256_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   output      stat_type    stat,
   output      logic [31:0] hash_word
);
   logic [5:0]   fill_ff, fill_in;
   logic         full_ff, full_in;
   logic [63:0]  count_ff, count_in;
   logic [255:0] chain_ff, chain_in;
   logic [31:0]  w_ff [16];
   logic [31:0]  v_ff [8];
   logic [5:0]   rnd_ff, rnd_in;
   logic [7:0]   wr_byte;
   logic [63:0]  bit_len;
   logic [31:0]  wi, s0, s1, t1, t2, w15, w2, wnew;
   logic [31:0]  a, b, c, d, e, f, g, h;

   assign bit_len = {count_ff[60:0], 3'b000};
   assign wr_byte = ctrl.len_sel ? bit_len[6'd56 - {ctrl.len_idx, 3'b000} +: 8]
                                 : ctrl.wr_data;

   assign {a, b, c, d, e, f, g, h} = {v_ff[0], v_ff[1], v_ff[2], v_ff[3],
                                      v_ff[4], v_ff[5], v_ff[6], v_ff[7]};
   assign w15  = w_ff[1];
   assign w2   = w_ff[14];
   assign s0   = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
   assign s1   = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
   assign wnew = w_ff[0] + s0 + w_ff[9] + s1;
   assign wi   = (rnd_ff < 6'd16) ? w_ff[rnd_ff[3:0]] : wnew;
   assign t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & f) ^ (~e & g)) + round_k(rnd_ff) + wi;
   assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & b) ^ (a & c) ^ (b & c));

   always_ff @(posedge clock) begin
      if (ctrl.start_blk) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= chain_ff[255-32*i -: 32];
         end
      end else if (ctrl.round_en) begin
         if (rnd_ff >= 6'd16) begin
            for (int i = 0; i < 15; i++) begin
               w_ff[i] <= w_ff[i+1];
            end
            w_ff[15] <= wnew;
         end
         v_ff[7] <= g; v_ff[6] <= f; v_ff[5] <= e; v_ff[4] <= d + t1;
         v_ff[3] <= c; v_ff[2] <= b; v_ff[1] <= a; v_ff[0] <= t1 + t2;
      end else if (ctrl.wr_byte) begin
         w_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      full_in  = 1'b0;
      count_in = count_ff;
      chain_in = chain_ff;
      rnd_in   = rnd_ff;
      if (ctrl.wr_byte) begin
         fill_in = fill_ff + 6'd1;
         full_in = (fill_ff == 6'd63);
      end
      if (ctrl.count_byte) count_in = count_ff + 64'd1;
      if (ctrl.start_blk) rnd_in = '0;
      else if (ctrl.round_en) rnd_in = rnd_ff + 6'd1;
      if (ctrl.finish_blk) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[255-32*i -: 32] = chain_ff[255-32*i -: 32] + v_ff[i];
         end
      end
      if (ctrl.init_hash) begin
         chain_in = InitHash;
         count_in = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         full_ff  <= 1'b0;
         count_ff <= '0;
         chain_ff <= InitHash;
         rnd_ff   <= '0;
      end else begin
         fill_ff  <= fill_in;
         full_ff  <= full_in;
         count_ff <= count_in;
         chain_ff <= chain_in;
         rnd_ff   <= rnd_in;
      end
   end

   assign stat.fill       = fill_ff;
   assign stat.block_full = full_ff;
   assign stat.last_round = (rnd_ff == 6'd63);
   assign hash_word = chain_ff[8'(255 - 32*int'(ctrl.out_idx)) -: 32];
endmodule
`default_nettype wire

// ===== design/sha256_ctrl.sv =====
// Controller: byte intake, padding sequence, compression and digest output.
`default_nettype none
module sha256_ctrl import sha256_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_word_index,
   input  wire stat_type    stat,
   output      ctrl_type    ctrl
);
   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StCheck = 3'd1;
   localparam logic [2:0] StRound = 3'd2;
   localparam logic [2:0] StAdd   = 3'd3;
   localparam logic [2:0] StPad   = 3'd4;
   localparam logic [2:0] StLen   = 3'd5;
   localparam logic [2:0] StOut   = 3'd6;
   localparam logic [2:0] StInit  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;
   logic       pad_ff, pad_in;
   logic [2:0] idx_ff, idx_in;
   logic       acc;

   assign req_ready      = (state_ff == StIdle);
   assign acc            = req_valid && req_ready;
   assign rsp_valid      = (state_ff == StOut);
   assign rsp_word_index = idx_ff;

   always_comb begin
      state_in = state_ff;
      fin_in   = fin_ff;
      pad_in   = pad_ff;
      idx_in   = idx_ff;
      ctrl     = '0;
      ctrl.out_idx = idx_ff;
      ctrl.len_idx = idx_ff;
      case (state_ff)
         StIdle: begin
            ctrl.wr_data = req_msg_byte;
            if (acc) begin
               ctrl.wr_byte    = req_byte_present;
               ctrl.count_byte = req_byte_present;
               fin_in = req_end_of_message;
               pad_in = 1'b0;
               if (req_byte_present || req_end_of_message) state_in = StCheck;
            end
         end
         StCheck: begin
            if (stat.block_full) begin
               ctrl.start_blk = 1'b1;
               state_in = StRound;
            end else if (!fin_ff) begin
               state_in = StIdle;
            end else if (!pad_ff) begin
               ctrl.wr_byte = 1'b1;
               ctrl.wr_data = 8'h80;
               pad_in = 1'b1;
            end else if (stat.fill != 6'(PadStart)) begin
               state_in = StPad;
            end else begin
               idx_in = '0;
               state_in = StLen;
            end
         end
         StRound: begin
            ctrl.round_en = 1'b1;
            if (stat.last_round) state_in = StAdd;
         end
         StAdd: begin
            ctrl.finish_blk = 1'b1;
            idx_in = '0;
            state_in = (fin_ff && pad_ff && stat.fill == '0 && idx_ff == 3'd7)
                       ? StOut : StCheck;
         end
         StPad: begin
            ctrl.wr_byte = 1'b1;
            state_in = StCheck;
         end
         StLen: begin
            ctrl.wr_byte = 1'b1;
            ctrl.len_sel = 1'b1;
            if (idx_ff == 3'd7) state_in = StCheck;
            else idx_in = idx_ff + 3'd1;
         end
         StOut: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) state_in = StInit;
            end
         end
         StInit: begin
            ctrl.init_hash = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         fin_ff   <= 1'b0;
         pad_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
         pad_ff   <= pad_in;
         idx_ff   <= idx_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/sha256_digest.sv =====
// Top level: SHA-256 byte-stream digest engine.
// Intake: each byte is taken in StIdle, then StCheck starts compression of a filled
// block (one round per cycle). End of message: the 0x80 byte, zero pad bytes via StPad
// and eight length bytes via StLen, with compressions between; then eight response
// words, one per cycle while accepted, and StInit to reinit.
// Throughput: one request at a time; the round loop sets the block rate.
// Reset: synchronous, restores the initial hash and clears the byte count.
`default_nettype none
module sha256_digest import sha256_pkg::*; (
   input wire logic     clock,
   input wire logic     reset,
   sha256_req_if.sink   req,
   sha256_rsp_if.source rsp
);
   ctrl_type ctrl;
   stat_type stat;
   logic [31:0] hash_word;
   logic [2:0]  word_idx;

   sha256_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_msg_byte(req.msg_byte),
      .req_byte_present(req.byte_present), .req_end_of_message(req.end_of_message),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_word_index(word_idx),
      .stat, .ctrl);

   sha256_datapath u_dp (.clock, .reset, .ctrl, .stat, .hash_word);

   assign rsp.digest_word = hash_word;
   assign rsp.word_index  = word_idx;
   assign rsp.last_word   = (word_idx == 3'd7);

   assert property (@(posedge clock) disable iff (reset) !(req.ready && rsp.valid))
      else $error("request taken during response");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.last_word |=> !rsp.valid)
      else $error("response continued after last word");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(word_idx))
      else $error("response index moved while stalled");
endmodule
`default_nettype wire

// ===== tb/sha256_digest_checker.sv =====
// Checker: watches both channels, predicts SHA-256 digests and compares responses.
module sha256_digest_checker import sha256_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   sha256_req_if     req,
   sha256_rsp_if     rsp,
   output int        fail_count,
   output int        pending_count,
   output int        digest_count
);
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_t;

   logic [31:0] chain_words [8];
   logic [7:0]  block_bytes [64];
   logic [63:0] byte_total;
   int          fill_pos;
   digest_item_t digest_queue [$];

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] init_word(input int i);
      return InitHash[255 - 32 * i -: 32];
   endfunction

   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wi, s0, s1, t1, t2, w15, w2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] = chain_words[i];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            wi = w[i];
         end else begin
            w15 = w[(i - 15) & 15];
            w2 = w[(i - 2) & 15];
            s0 = ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3);
            s1 = ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10);
            wi = w[i & 15] + s0 + w[(i - 7) & 15] + s1;
            w[i & 15] = wi;
         end
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + wi;
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_words[i] += v[i];
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      block_bytes[fill_pos] = b;
      fill_pos++;
      if (fill_pos == BlockBytes) begin
         compress_block();
         fill_pos = 0;
      end
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain_words[i] = init_word(i);
      byte_total = '0;
      fill_pos = 0;
   endtask

   task automatic predict_request(input logic [7:0] b, input logic present, input logic eom);
      logic [63:0] bits;
      digest_item_t d;
      if (present) begin
         absorb_byte(b);
         byte_total++;
      end
      if (eom) begin
         bits = byte_total << 3;
         absorb_byte(8'h80);
         while (fill_pos != PadStart) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(bits[63 - 8 * i -: 8]);
         for (int i = 0; i < 8; i++) begin
            d.digest_word = chain_words[i];
            d.word_index = i[2:0];
            d.last_word = (i == 7);
            digest_queue.push_back(d);
         end
         restart_message();
      end
   endtask

   assign pending_count = digest_queue.size();

   always @(posedge clock) begin
      digest_item_t e;
      if (reset) begin
         restart_message();
         digest_queue.delete();
         fail_count <= 0;
         digest_count <= 0;
      end else begin
         if (req.valid && req.ready)
            predict_request(req.msg_byte, req.byte_present, req.end_of_message);
         if (rsp.valid && rsp.ready) begin
            if (digest_queue.size() == 0) begin
               $error("unexpected response word %h", rsp.digest_word);
               fail_count <= fail_count + 1;
            end else begin
               e = digest_queue.pop_front();
               if (rsp.digest_word !== e.digest_word || rsp.word_index !== e.word_index
                   || rsp.last_word !== e.last_word)
                  fail_count <= fail_count + 1;
               if (rsp.digest_word !== e.digest_word)
                  $error("digest_word expected %h actual %h", e.digest_word, rsp.digest_word);
               if (rsp.word_index !== e.word_index)
                  $error("word_index expected %0d actual %0d", e.word_index, rsp.word_index);
               if (rsp.last_word !== e.last_word)
                  $error("last_word expected %0d actual %0d", e.last_word, rsp.last_word);
               if (e.last_word) digest_count <= digest_count + 1;
            end
         end
      end
   end
endmodule

// ===== tb/sha256_digest_test.sv =====
// Testbench top: drives byte-stream requests and gives the verdict.
module sha256_digest_test;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, digest_count;
   int   cycle_count = 0;
   int   request_count = 0;
   bit   no_idle = 1'b0;
   bit   hold_rsp = 1'b0;

   sha256_req_if req ();
   sha256_rsp_if rsp ();

   sha256_digest i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   sha256_digest_checker i_checker (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_count(pending_count), .digest_count(digest_count));

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.msg_byte = '0;
      req.byte_present = 1'b0;
      req.end_of_message = 1'b0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // randomize receiver ready; hold off while pressure is applied
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp.ready <= 1'b0;
      else rsp.ready <= no_idle || ($urandom_range(99) >= 26);
   end

   task automatic send_request(input logic [7:0] b, input logic present, input logic eom);
      while (!no_idle && $urandom_range(99) < 26) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.msg_byte <= b;
      req.byte_present <= present;
      req.end_of_message <= eom;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      request_count++;
      @(negedge clock);
   endtask

   task automatic send_message(input int len, input bit tail_end);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b0);
         send_request(8'($urandom_range(255)), 1'b1, tail_end && i == len - 1);
      end
      if (!tail_end || len == 0) send_request(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: empty message, extreme bytes
      send_request(8'hff, 1'b0, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'h5a, 1'b0, 1'b0);
      send_request(8'ha5, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      send_message(3, 1'b1);
      send_message(4, 1'b0);
      // hold the receiver off so the block stalls its input
      hold_rsp = 1'b1;
      fork
         begin
            send_message(2, 1'b1);
            send_message(1, 1'b1);
         end
         begin
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
         end
      join
      // random messages across block and padding boundaries
      send_message(55, 1'b1);
      send_message(64, 1'b1);
      no_idle = 1'b1;
      send_message(30 + $urandom_range(10), 1'($urandom_range(1)));
      no_idle = 1'b0;
      while (request_count < 200)
         send_message($urandom_range(20), 1'($urandom_range(1)));
      req.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Run covered %0d requests and %0d digests, including padding edge lengths.",
               request_count, digest_count);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule
